// ----- src/deq_pkg.sv -----
// ============================================================================
// deq_pkg: shared definitions for the double-ended queue engine
// Request codes, status codes, data width, default depth and controller states.
// ============================================================================
package deq_pkg;

	localparam int unsigned DEQ_DEPTH = 16;
	localparam int unsigned DATA_W = 8;

	localparam logic [2:0] KIND_PUSH_BACK = 3'd0;
	localparam logic [2:0] KIND_PUSH_FRONT = 3'd1;
	localparam logic [2:0] KIND_POP_FRONT = 3'd2;
	localparam logic [2:0] KIND_POP_BACK = 3'd3;
	localparam logic [2:0] KIND_CONTAINS = 3'd4;
	localparam logic [2:0] KIND_REMOVE = 3'd5;
	localparam logic [2:0] KIND_REVERSE = 3'd6;
	localparam logic [2:0] KIND_CLEAR = 3'd7;

	localparam logic [1:0] STAT_OK = 2'd0;
	localparam logic [1:0] STAT_EMPTY = 2'd1;
	localparam logic [1:0] STAT_FULL = 2'd2;

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_SCAN = 6'b000010,
		ST_SHIFT = 6'b000100,
		ST_DROP = 6'b001000,
		ST_LOAD = 6'b010000,
		ST_DONE = 6'b100000
	} deq_state_t;

endpackage

// ----- src/deq_ram.sv -----
// ============================================================================
// deq_ram: generic simple dual-port RAM
// One write port and one read port; the read data is registered.
// ============================================================================
module deq_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ----- src/double_ended_queue_engine.sv -----
// ============================================================================
// double_ended_queue_engine: bounded double-ended queue of bytes
// Ring store in one RAM with registered copies of both end values.
// ============================================================================
// The queue holds up to DEPTH bytes in a ring buffer RAM with a registered read.
// Every request gives exactly one result. A push, reverse or clear goes straight
// from the input transfer to the result state, and so does a pop on an empty
// queue. Any other pop also passes the drop state and then, unless it leaves the
// queue empty, a load state that reloads the new end value. Contains and remove
// read the store one entry per cycle in logical order. A remove that takes an
// end entry then finishes like a pop. A remove in the middle moves the entries
// stored after it down one place per cycle through the single RAM port pair.
// The next request is taken in the cycle after the result is registered; a
// waiting result does not block it, but the next result is held until the
// waiting one has been transferred.
module double_ended_queue_engine
	import deq_pkg::*;
#(
	parameter int unsigned DEPTH = DEQ_DEPTH
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [2:0]                 kind,
	input  logic [DATA_W-1:0]          value,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [1:0]                 status,
	output logic                       found,
	output logic [$clog2(DEPTH+1)-1:0] count,
	output logic [DATA_W-1:0]          front_value,
	output logic [DATA_W-1:0]          back_value
);

	localparam int unsigned AW = $clog2(DEPTH);
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam int unsigned SW = CW + 1;
	localparam logic [SW-1:0] DEPTH_S = SW'(DEPTH);

	deq_state_t state_q;
	logic [AW-1:0] head_q;
	logic [CW-1:0] cnt_q;
	logic rev_q;
	logic [DATA_W-1:0] pf_q;
	logic [DATA_W-1:0] pl_q;
	logic [2:0] kind_q;
	logic [DATA_W-1:0] value_q;
	logic [1:0] status_q;
	logic found_q;
	logic drop_start_q;
	logic [CW-1:0] i_q;
	logic [CW-1:0] sh_q;
	logic rd_vld_s1;
	logic [CW-1:0] rd_off_s1;
	logic out_valid_q;

	logic we;
	logic [AW-1:0] waddr;
	logic [DATA_W-1:0] wdata;
	logic [AW-1:0] raddr;
	logic [DATA_W-1:0] rdata;

	logic accept;
	logic push_start;
	logic pop_start;
	logic [AW-1:0] head_dec;
	logic [AW-1:0] head_inc;
	logic scan_issue;
	logic [CW-1:0] scan_off;
	logic sh_issue;
	logic [CW-1:0] drop_cnt;
	logic [AW-1:0] drop_head;
	logic match;

	function automatic logic [AW-1:0] slot_f(input logic [AW-1:0] h, input logic [CW-1:0] off);
		logic [SW-1:0] s;
		s = SW'(h) + SW'(off);
		if (s >= DEPTH_S) begin
			s = s - DEPTH_S;
		end
		return s[AW-1:0];
	endfunction

	deq_ram #(
		.WIDTH(DATA_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	assign in_ready = (state_q == ST_IDLE);
	assign accept = in_valid && in_ready;
	assign push_start = (kind == KIND_PUSH_FRONT) != rev_q;
	assign pop_start = (kind == KIND_POP_FRONT) != rev_q;
	assign head_dec = (head_q == '0) ? AW'(DEPTH - 1) : head_q - AW'(1);
	assign head_inc = slot_f(head_q, CW'(1));
	assign scan_issue = (i_q < cnt_q);
	assign scan_off = rev_q ? (cnt_q - CW'(1) - i_q) : i_q;
	assign sh_issue = (sh_q < cnt_q);
	assign drop_cnt = cnt_q - CW'(1);
	assign drop_head = drop_start_q ? head_inc : head_q;
	assign match = rd_vld_s1 && (rdata == value_q);

	always_comb begin
		we = 1'b0;
		waddr = slot_f(head_q, cnt_q);
		wdata = value;
		raddr = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && (kind == KIND_PUSH_BACK || kind == KIND_PUSH_FRONT)
						&& cnt_q != CW'(DEPTH)) begin
					we = 1'b1;
					if (push_start) begin
						waddr = head_dec;
					end
				end
			end
			ST_SCAN: begin
				raddr = slot_f(head_q, scan_off);
			end
			ST_SHIFT: begin
				raddr = slot_f(head_q, sh_q);
				we = rd_vld_s1;
				waddr = slot_f(head_q, rd_off_s1 - CW'(1));
				wdata = rdata;
			end
			ST_DROP: begin
				raddr = drop_start_q ? drop_head : slot_f(head_q, drop_cnt - CW'(1));
			end
			ST_LOAD, ST_DONE: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			head_q <= '0;
			cnt_q <= '0;
			rev_q <= 1'b0;
			out_valid_q <= 1'b0;
			rd_vld_s1 <= 1'b0;
		end else begin
			if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						kind_q <= kind;
						value_q <= value;
						status_q <= STAT_OK;
						found_q <= 1'b0;
						i_q <= '0;
						rd_vld_s1 <= 1'b0;
						state_q <= ST_DONE;
						unique case (kind)
							KIND_PUSH_BACK, KIND_PUSH_FRONT: begin
								if (cnt_q == CW'(DEPTH)) begin
									status_q <= STAT_FULL;
								end else begin
									cnt_q <= cnt_q + CW'(1);
									if (push_start) begin
										head_q <= head_dec;
										pf_q <= value;
										if (cnt_q == '0) begin
											pl_q <= value;
										end
									end else begin
										pl_q <= value;
										if (cnt_q == '0) begin
											pf_q <= value;
										end
									end
								end
							end
							KIND_POP_FRONT, KIND_POP_BACK: begin
								if (cnt_q == '0) begin
									status_q <= STAT_EMPTY;
								end else begin
									drop_start_q <= pop_start;
									state_q <= ST_DROP;
								end
							end
							KIND_CONTAINS: begin
								state_q <= ST_SCAN;
							end
							KIND_REMOVE: begin
								if (cnt_q == '0) begin
									status_q <= STAT_EMPTY;
								end else begin
									state_q <= ST_SCAN;
								end
							end
							KIND_REVERSE: begin
								rev_q <= ~rev_q;
							end
							KIND_CLEAR: begin
								cnt_q <= '0;
								head_q <= '0;
								rev_q <= 1'b0;
							end
							default: begin
							end
						endcase
					end
				end
				ST_SCAN: begin
					rd_vld_s1 <= scan_issue;
					rd_off_s1 <= scan_off;
					if (scan_issue) begin
						i_q <= i_q + CW'(1);
					end
					if (match) begin
						found_q <= 1'b1;
						rd_vld_s1 <= 1'b0;
						if (kind_q == KIND_REMOVE) begin
							if (rd_off_s1 == '0) begin
								drop_start_q <= 1'b1;
								state_q <= ST_DROP;
							end else if (rd_off_s1 == drop_cnt) begin
								drop_start_q <= 1'b0;
								state_q <= ST_DROP;
							end else begin
								sh_q <= rd_off_s1 + CW'(1);
								state_q <= ST_SHIFT;
							end
						end else begin
							state_q <= ST_DONE;
						end
					end else if (!scan_issue && !rd_vld_s1) begin
						state_q <= ST_DONE;
					end
				end
				ST_SHIFT: begin
					rd_vld_s1 <= sh_issue;
					rd_off_s1 <= sh_q;
					if (sh_issue) begin
						sh_q <= sh_q + CW'(1);
					end
					if (!sh_issue && !rd_vld_s1) begin
						cnt_q <= drop_cnt;
						state_q <= ST_DONE;
					end
				end
				ST_DROP: begin
					cnt_q <= drop_cnt;
					if (drop_cnt == '0) begin
						head_q <= '0;
						state_q <= ST_DONE;
					end else begin
						head_q <= drop_head;
						state_q <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					if (drop_start_q) begin
						pf_q <= rdata;
					end else begin
						pl_q <= rdata;
					end
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	logic [1:0] status_o_q;
	logic found_o_q;
	logic [CW-1:0] count_o_q;
	logic [DATA_W-1:0] front_o_q;
	logic [DATA_W-1:0] back_o_q;

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && (!out_valid_q || out_ready)) begin
			status_o_q <= status_q;
			found_o_q <= found_q;
			count_o_q <= cnt_q;
			if (cnt_q == '0) begin
				front_o_q <= '0;
				back_o_q <= '0;
			end else begin
				front_o_q <= rev_q ? pl_q : pf_q;
				back_o_q <= rev_q ? pf_q : pl_q;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign status = status_o_q;
	assign found = found_o_q;
	assign count = count_o_q;
	assign front_value = front_o_q;
	assign back_value = back_o_q;

endmodule

// ----- dv/double_ended_queue_engine_tb.sv -----
`timescale 1ns / 1ps
// ============================================================================
// double_ended_queue_engine_tb: self-checking bench for the byte deque engine
// Requests are driven over a valid/ready channel with random gaps, and every
// result is compared field by field against a queue-state predictor. A short
// directed part covers the empty, full and end cases. Random traffic follows,
// along with a full-rate stretch and a long receiver hold-off that fills the
// engine and stalls its input.
// ============================================================================
module double_ended_queue_engine_tb
	import deq_pkg::*;
();

	localparam int QDEPTH = DEQ_DEPTH;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int HOLD_CYCLES = 300;
	localparam int DRAIN_CYCLES = 60;

	typedef struct packed {
		logic [1:0] status;
		logic       found;
		logic [4:0] count;
		logic [7:0] front;
		logic [7:0] back;
	} deq_result_t;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	logic [2:0] kind;
	logic [7:0] value;
	logic       out_valid;
	logic       out_ready;
	logic [1:0] status;
	logic       found;
	logic [4:0] count;
	logic [7:0] front_value;
	logic [7:0] back_value;

	logic [7:0]  mdl_ring [QDEPTH];
	int          mdl_head;
	int          mdl_count;
	bit          mdl_rev;
	deq_result_t expected_results [$];
	int          error_count;
	int          idle_cycles;
	bit          tx_no_gap;
	bit          rx_no_gap;
	int          rx_hold;
	logic [7:0]  value_pool [4];

	double_ended_queue_engine #(
		.DEPTH(QDEPTH)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.kind(kind),
		.value(value),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.found(found),
		.count(count),
		.front_value(front_value),
		.back_value(back_value)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic int ring_slot(input int off);
		return (mdl_head + off) % QDEPTH;
	endfunction

	function automatic int phys_offset(input int k);
		return mdl_rev ? (mdl_count - 1 - k) : k;
	endfunction

	function automatic logic [7:0] logical_at(input int k);
		return mdl_ring[ring_slot(phys_offset(k))];
	endfunction

	function automatic int find_pos(input logic [7:0] v);
		for (int k = 0; k < mdl_count; k++) begin
			if (logical_at(k) == v)
				return k;
		end
		return -1;
	endfunction

	function automatic deq_result_t deque_predict(input logic [2:0] k, input logic [7:0] v);
		deq_result_t r;
		bit at_start;
		int pos;
		r = '0;
		r.status = STAT_OK;
		case (k)
			KIND_PUSH_BACK, KIND_PUSH_FRONT: begin
				if (mdl_count >= QDEPTH) begin
					r.status = STAT_FULL;
				end else begin
					at_start = (k == KIND_PUSH_FRONT) != mdl_rev;
					if (at_start) begin
						mdl_head = (mdl_head + QDEPTH - 1) % QDEPTH;
						mdl_ring[mdl_head] = v;
					end else begin
						mdl_ring[ring_slot(mdl_count)] = v;
					end
					mdl_count++;
				end
			end
			KIND_POP_FRONT, KIND_POP_BACK: begin
				if (mdl_count == 0) begin
					r.status = STAT_EMPTY;
				end else begin
					at_start = (k == KIND_POP_FRONT) != mdl_rev;
					if (at_start)
						mdl_head = (mdl_head + 1) % QDEPTH;
					mdl_count--;
					if (mdl_count == 0)
						mdl_head = 0;
				end
			end
			KIND_CONTAINS: begin
				r.found = (find_pos(v) >= 0);
			end
			KIND_REMOVE: begin
				if (mdl_count == 0) begin
					r.status = STAT_EMPTY;
				end else begin
					pos = find_pos(v);
					if (pos >= 0) begin
						r.found = 1'b1;
						for (int off = phys_offset(pos); off + 1 < mdl_count; off++)
							mdl_ring[ring_slot(off)] = mdl_ring[ring_slot(off + 1)];
						mdl_count--;
						if (mdl_count == 0)
							mdl_head = 0;
					end
				end
			end
			KIND_REVERSE: begin
				mdl_rev = !mdl_rev;
			end
			default: begin
				mdl_count = 0;
				mdl_head = 0;
				mdl_rev = 1'b0;
			end
		endcase
		r.count = 5'(mdl_count);
		if (mdl_count != 0) begin
			r.front = logical_at(0);
			r.back = logical_at(mdl_count - 1);
		end
		return r;
	endfunction

	task automatic compare_field(input string name, input logic [7:0] exp, input logic [7:0] act);
		if (exp !== act) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp, act);
			error_count++;
		end
	endtask

	always @(posedge clk) begin
		deq_result_t exp;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual status %0h count %0d",
						$time, status, count);
					error_count++;
				end else begin
					exp = expected_results.pop_front();
					compare_field("status", 8'(exp.status), 8'(status));
					compare_field("found", 8'(exp.found), 8'(found));
					compare_field("count", 8'(exp.count), 8'(count));
					compare_field("front_value", exp.front, front_value);
					compare_field("back_value", exp.back, back_value);
				end
			end
			if (in_valid && in_ready)
				expected_results.push_back(deque_predict(kind, value));
		end
	end

	initial begin
		idle_cycles = 0;
		while (idle_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("TEST FAILED");
		$finish;
	end

	// Result side: random stalls per transfer, plus an optional long hold-off.
	initial begin
		int gap;
		out_ready = 1'b0;
		wait (arst_n);
		@(negedge clk);
		forever begin
			if (rx_hold > 0) begin
				out_ready = 1'b0;
				repeat (rx_hold) @(negedge clk);
				rx_hold = 0;
			end
			gap = rx_no_gap ? 0 : $urandom_range(19);
			if (gap > 0) begin
				out_ready = 1'b0;
				repeat (gap) @(negedge clk);
			end
			out_ready = 1'b1;
			@(posedge clk);
			while (!out_valid)
				@(posedge clk);
			@(negedge clk);
		end
	end

	task automatic send_req(input logic [2:0] k, input logic [7:0] v);
		int gap;
		gap = tx_no_gap ? 0 : $urandom_range(19);
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		kind = k;
		value = v;
		in_valid = 1'b1;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	function automatic logic [2:0] pick_kind(input int push_pct);
		int r;
		r = $urandom_range(99);
		if (r < push_pct)
			return $urandom_range(1) ? KIND_PUSH_FRONT : KIND_PUSH_BACK;
		else if (r < 80)
			return $urandom_range(1) ? KIND_POP_FRONT : KIND_POP_BACK;
		else if (r < 88)
			return KIND_CONTAINS;
		else if (r < 96)
			return KIND_REMOVE;
		else if (r < 99)
			return KIND_REVERSE;
		else
			return KIND_CLEAR;
	endfunction

	function automatic logic [7:0] pick_value();
		if ($urandom_range(9) < 7)
			return value_pool[$urandom_range(3)];
		return 8'($urandom_range(255));
	endfunction

	task automatic refresh_pool();
		for (int i = 0; i < 4; i++)
			value_pool[i] = 8'($urandom_range(255));
	endtask

	task automatic test_empty_requests();
		send_req(KIND_POP_FRONT, 8'h00);
		send_req(KIND_POP_BACK, 8'hFF);
		send_req(KIND_REMOVE, 8'h00);
		send_req(KIND_CONTAINS, 8'hFF);
	endtask

	task automatic test_end_operations();
		send_req(KIND_PUSH_BACK, 8'h00);
		send_req(KIND_PUSH_FRONT, 8'hFF);
		send_req(KIND_REVERSE, 8'h55);
		send_req(KIND_PUSH_BACK, 8'h5A);
		send_req(KIND_PUSH_FRONT, 8'h3C);
		send_req(KIND_CONTAINS, 8'hFF);
		send_req(KIND_CONTAINS, 8'h12);
		send_req(KIND_REMOVE, 8'h3C);
		send_req(KIND_REMOVE, 8'h77);
		send_req(KIND_REMOVE, 8'h00);
		send_req(KIND_POP_FRONT, 8'hAA);
		send_req(KIND_POP_BACK, 8'hAA);
	endtask

	task automatic test_fill_and_clear();
		send_req(KIND_REVERSE, 8'h00);
		repeat (QDEPTH)
			send_req($urandom_range(1) ? KIND_PUSH_FRONT : KIND_PUSH_BACK,
				8'($urandom_range(255)));
		send_req(KIND_PUSH_FRONT, 8'hA5);
		send_req(KIND_PUSH_BACK, 8'h5A);
		send_req(KIND_CLEAR, 8'hC3);
	endtask

	task automatic test_random_mix(input int n, input int push_pct);
		refresh_pool();
		for (int i = 0; i < n; i++) begin
			if (i % 64 == 63)
				refresh_pool();
			send_req(pick_kind(push_pct), pick_value());
		end
	endtask

	task automatic test_streaming();
		tx_no_gap = 1'b1;
		rx_no_gap = 1'b1;
		test_random_mix(150, 50);
		tx_no_gap = 1'b0;
		rx_no_gap = 1'b0;
	endtask

	task automatic test_backpressure();
		rx_hold = HOLD_CYCLES;
		tx_no_gap = 1'b1;
		test_random_mix(40, 60);
		tx_no_gap = 1'b0;
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		kind = KIND_PUSH_BACK;
		value = 8'h00;
		error_count = 0;
		tx_no_gap = 1'b0;
		rx_no_gap = 1'b0;
		rx_hold = 0;
		mdl_head = 0;
		mdl_count = 0;
		mdl_rev = 1'b0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;

		test_empty_requests();
		test_end_operations();
		test_fill_and_clear();
		test_random_mix(300, 50);
		test_random_mix(300, 72);
		test_random_mix(250, 28);
		test_streaming();
		test_backpressure();
		test_random_mix(300, 55);

		in_valid = 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0 && expected_results.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

// ----- files.f -----
src/deq_pkg.sv
src/deq_ram.sv
src/double_ended_queue_engine.sv
dv/double_ended_queue_engine_tb.sv
